>>> rtl/hbd_pkg.sv
`default_nettype none

package hbd_pkg;

    localparam int SIDE       = 64;
    localparam int OUT_SIDE   = 16;
    localparam int USED_SIDE  = (OUT_SIDE < SIDE / 4) ? OUT_SIDE : SIDE / 4;
    localparam int COVERED    = 4 * USED_SIDE;

    localparam int HEIGHT_W   = 16;
    localparam int SUM_W      = 20;
    localparam int POS_W      = $clog2(SIDE);
    localparam int BLK_W      = POS_W - 2;
    localparam int IDX_W      = (USED_SIDE > 1) ? $clog2(USED_SIDE) : 1;

    typedef logic [POS_W-1:0]           t_pos;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [HEIGHT_W-1:0] t_height;

    typedef struct packed {
        t_height          sample;
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             done;
        logic             last;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/heightmap_box_downsample_4x4.sv
// Path: an accepted input item is registered in the accumulate stage, and the block result it
// finishes is registered in the output register.
// Throughput: one input item per cycle; the input stalls only while the accumulate stage
// holds a block-finishing item and the output holds a result that is not taken.
// Reset: synchronous, active low; clears positions and valid flags, partial sums are not cleared.
`default_nettype none

module heightmap_box_downsample_4x4
    import hbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [HEIGHT_W-1:0] i_s_tdata,  // [15:0] height
    input  wire logic [0:0]          i_s_tuser,  // [0] start_of_map
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [HEIGHT_W-1:0]      o_m_tdata,  // [15:0] average
    output logic                     o_m_tlast   // last_of_map
);

    localparam t_pos       POS_LAST  = t_pos'(SIDE - 1);
    localparam logic [POS_W:0] COVER_LIM = (POS_W + 1)'(COVERED);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(USED_SIDE - 1);

    t_pos   r_col, r_row;
    t_pos   cur_col, cur_row;
    t_stage r_stage, n_stage;
    logic   r_stage_valid;
    logic   r_out_valid;
    logic [HEIGHT_W-1:0] r_out_data;
    logic   r_out_last;
    t_sum   sums [USED_SIDE];
    t_sum   n_sum;
    logic   s_accept, out_free, stage_move, covered;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign stage_move = !r_stage_valid || !r_stage.done || out_free;
    assign o_s_tready = stage_move;

    assign cur_col = i_s_tuser[0] ? '0 : r_col;
    assign cur_row = i_s_tuser[0] ? '0 : r_row;
    assign covered = ({1'b0, cur_col} < COVER_LIM) && ({1'b0, cur_row} < COVER_LIM);

    always_comb begin
        n_stage.sample = t_height'(i_s_tdata);
        n_stage.idx    = IDX_W'(cur_col[POS_W-1:2]);
        n_stage.first  = (cur_col[1:0] == 2'd0) && (cur_row[1:0] == 2'd0);
        n_stage.done   = (cur_col[1:0] == 2'd3) && (cur_row[1:0] == 2'd3);
        n_stage.last   = (cur_col[POS_W-1:2] == BLK_LAST) && (cur_row[POS_W-1:2] == BLK_LAST);
    end

    always_comb begin
        if (r_stage.first) begin
            n_sum = t_sum'(r_stage.sample);
        end else begin
            n_sum = sums[r_stage.idx] + t_sum'(r_stage.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_accept) begin
                if (cur_col == POS_LAST) begin
                    r_col <= '0;
                    r_row <= (cur_row == POS_LAST) ? '0 : cur_row + t_pos'(1);
                end else begin
                    r_col <= cur_col + t_pos'(1);
                    r_row <= cur_row;
                end
            end
            if (stage_move) begin
                r_stage_valid <= s_accept && covered;
            end
            if (out_free) begin
                r_out_valid <= r_stage_valid && r_stage.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move && s_accept) begin
            r_stage <= n_stage;
        end
        if (r_stage_valid && stage_move) begin
            sums[r_stage.idx] <= n_sum;
        end
        if (out_free && r_stage_valid && r_stage.done) begin
            r_out_data <= n_sum[SUM_W-1:SUM_W-HEIGHT_W];
            r_out_last <= r_stage.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/hbd_checker.sv
`default_nettype none

module hbd_checker
    import hbd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_tvalid,
    input wire logic                o_s_tready,
    input wire logic                i_m_tready,
    input wire logic                o_m_tvalid,
    input wire logic [HEIGHT_W-1:0] o_m_tdata,
    input wire logic                o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("output item without input item two cycles before");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output is empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind heightmap_box_downsample_4x4 hbd_checker u_hbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
